### rtl/gfrns_pkg.sv
// Shared types, codes and constants of the grid neighbor search block.
package gfrns_pkg;

  localparam int MAX_PARTICLES = 1024;
  localparam int IDX_W         = 10;
  localparam int CNT_W         = 11;
  localparam int POS_W         = 24;
  localparam int DIFF_W        = 25;
  localparam int PROD_W        = 50;
  localparam int SQ_W          = 48;
  localparam int ACC_W         = 50;
  localparam int INV_W         = 24;
  localparam int RSQ_W         = 48;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 48;
  localparam int FRAC_SHIFT    = 28;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_LOAD  = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OUTSIDE  = 2'd1,
    ST_FULL     = 2'd2,
    ST_UNLOADED = 2'd3
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_INV_RADIUS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_SQ  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z   = 3'd4;

  // Datapath operations, one per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_CLEAR,
    OP_EMIT_ST,
    OP_LMUL,
    OP_LCELL,
    OP_HEAD_RD,
    OP_HCHK_RD,
    OP_LINK,
    OP_SETHEAD,
    OP_STORE,
    OP_QRD,
    OP_QLD,
    OP_NBR,
    OP_ADV,
    OP_DMUL,
    OP_DSUM,
    OP_ACCEPT,
    OP_MORE,
    OP_NEXT,
    OP_FINAL
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] axis;
    status_t    st;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic q_loaded;
    logic outside;
    logic hvalid;
    logic nbr_in;
    logic off_last;
    logic hit;
    logic n_full;
    logic pend_v;
    logic next_end;
    logic slot_free;
  } dp_stat_t;

endpackage

### rtl/grid_fixed_radius_neighbor_search.sv
// Top level of the uniform-grid fixed-radius neighbor search.
// Clear, load and query requests are taken one at a time; in_stall stays high while a
// request is worked. On a load one 25x25 multiplier is shared over the three axes,
// then the cell head and tail and the head's cell tag are read, and the list link or
// the cell head is written before the particle is stored. A load that finds the store
// full or lies outside the grid, and a query of an unloaded index, end with a status
// result. Any other query walks the cell lists of the neighbor cells inside the grid
// and makes three squarings per candidate particle on the same shared multiplier; it
// stops at the first neighbor past the result limit. Every result that meets a full
// result register waits while out_stall holds it. Cell heads need no clearing
// pass: a head counts only if it is below the fill count and that particle is tagged
// with the same cell. A result register decouples the output, so a request is taken
// while the last result still waits.
module grid_fixed_radius_neighbor_search #(
  parameter int GRID_X        = 16,
  parameter int GRID_Y        = 16,
  parameter int GRID_Z        = 16,
  parameter int MAX_NEIGHBORS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_func,
  input  logic signed [gfrns_pkg::POS_W-1:0]  in_pos_x,
  input  logic signed [gfrns_pkg::POS_W-1:0]  in_pos_y,
  input  logic signed [gfrns_pkg::POS_W-1:0]  in_pos_z,
  input  logic [gfrns_pkg::IDX_W-1:0]         in_query_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_status,
  output logic [gfrns_pkg::IDX_W-1:0]         out_assigned_index,
  output logic [gfrns_pkg::IDX_W-1:0]         out_neighbor_index,
  output logic                                out_last,
  output logic                                out_truncated,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gfrns_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gfrns_pkg::CFG_DATA_W-1:0]    cfg_data
);

  gfrns_pkg::dp_cmd_t  cmd;
  gfrns_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  gfrns_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  gfrns_datapath #(
    .GRID_X        (GRID_X),
    .GRID_Y        (GRID_Y),
    .GRID_Z        (GRID_Z),
    .MAX_NEIGHBORS (MAX_NEIGHBORS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_pos_z           (in_pos_z),
    .in_query_index     (in_query_index),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_assigned_index (out_assigned_index),
    .out_neighbor_index (out_neighbor_index),
    .out_last           (out_last),
    .out_truncated      (out_truncated)
  );

endmodule

### rtl/gfrns_ctrl.sv
// Controller state machine sequencing clear, load and query requests.
module gfrns_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_func,
  output logic                in_stall,
  output gfrns_pkg::dp_cmd_t  cmd,
  input  gfrns_pkg::dp_stat_t stat
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLR,
    S_EMIT,
    S_LCHK,
    S_LMUL,
    S_LCELL,
    S_LOUT,
    S_HCHK,
    S_HVAL,
    S_STORE,
    S_QCHK,
    S_QLD,
    S_NBR,
    S_HEAD,
    S_ADV,
    S_DMUL,
    S_DSUM,
    S_HIT,
    S_NEXT,
    S_FINAL
  } state_t;

  state_t              state_r, state_nxt;
  logic [1:0]          axis_r, axis_nxt;
  gfrns_pkg::status_t  st_r, st_nxt;
  logic                is_query_r, is_query_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Next state and datapath command
  always_comb begin
    state_nxt    = state_r;
    axis_nxt     = axis_r;
    st_nxt       = st_r;
    is_query_nxt = is_query_r;
    cmd.op       = gfrns_pkg::OP_NONE;
    cmd.axis     = axis_r;
    cmd.st       = st_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = gfrns_pkg::OP_CAPTURE;
          case (gfrns_pkg::func_t'(in_func))
            gfrns_pkg::FUNC_CLEAR: state_nxt = S_CLR;
            gfrns_pkg::FUNC_LOAD: begin
              state_nxt    = S_LCHK;
              is_query_nxt = 1'b0;
            end
            gfrns_pkg::FUNC_QUERY: begin
              state_nxt    = S_QCHK;
              is_query_nxt = 1'b1;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLR: begin
        if (stat.slot_free) begin
          cmd.op    = gfrns_pkg::OP_CLEAR;
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (stat.slot_free) begin
          cmd.op    = gfrns_pkg::OP_EMIT_ST;
          state_nxt = S_IDLE;
        end
      end
      S_LCHK: begin
        if (stat.full) begin
          st_nxt    = gfrns_pkg::ST_FULL;
          state_nxt = S_EMIT;
        end else begin
          axis_nxt  = 2'd0;
          state_nxt = S_LMUL;
        end
      end
      S_LMUL: begin
        cmd.op    = gfrns_pkg::OP_LMUL;
        state_nxt = S_LCELL;
      end
      S_LCELL: begin
        cmd.op = gfrns_pkg::OP_LCELL;
        if (axis_r == 2'd2) begin
          state_nxt = S_LOUT;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = S_LMUL;
        end
      end
      S_LOUT: begin
        if (stat.outside) begin
          st_nxt    = gfrns_pkg::ST_OUTSIDE;
          state_nxt = S_EMIT;
        end else begin
          cmd.op    = gfrns_pkg::OP_HEAD_RD;
          state_nxt = S_HCHK;
        end
      end
      S_HCHK: begin
        cmd.op    = gfrns_pkg::OP_HCHK_RD;
        state_nxt = S_HVAL;
      end
      S_HVAL: begin
        if (!is_query_r) begin
          if (stat.hvalid) begin
            cmd.op = gfrns_pkg::OP_LINK;
          end else begin
            cmd.op = gfrns_pkg::OP_SETHEAD;
          end
          state_nxt = S_STORE;
        end else if (stat.hvalid) begin
          axis_nxt  = 2'd0;
          state_nxt = S_DMUL;
        end else begin
          state_nxt = S_ADV;
        end
      end
      S_STORE: begin
        if (stat.slot_free) begin
          cmd.op    = gfrns_pkg::OP_STORE;
          state_nxt = S_IDLE;
        end
      end
      S_QCHK: begin
        if (!stat.q_loaded) begin
          st_nxt    = gfrns_pkg::ST_UNLOADED;
          state_nxt = S_EMIT;
        end else begin
          cmd.op    = gfrns_pkg::OP_QRD;
          state_nxt = S_QLD;
        end
      end
      S_QLD: begin
        cmd.op    = gfrns_pkg::OP_QLD;
        state_nxt = S_NBR;
      end
      S_NBR: begin
        if (stat.nbr_in) begin
          cmd.op    = gfrns_pkg::OP_NBR;
          state_nxt = S_HEAD;
        end else begin
          state_nxt = S_ADV;
        end
      end
      S_HEAD: begin
        cmd.op    = gfrns_pkg::OP_HEAD_RD;
        state_nxt = S_HCHK;
      end
      S_ADV: begin
        if (stat.off_last) begin
          state_nxt = S_FINAL;
        end else begin
          cmd.op    = gfrns_pkg::OP_ADV;
          state_nxt = S_NBR;
        end
      end
      S_DMUL: begin
        cmd.op = gfrns_pkg::OP_DMUL;
        if (axis_r == 2'd2) begin
          state_nxt = S_DSUM;
        end else begin
          axis_nxt = axis_r + 2'd1;
        end
      end
      S_DSUM: begin
        cmd.op    = gfrns_pkg::OP_DSUM;
        state_nxt = S_HIT;
      end
      S_HIT: begin
        if (!stat.hit) begin
          state_nxt = S_NEXT;
        end else if (stat.n_full) begin
          cmd.op    = gfrns_pkg::OP_MORE;
          state_nxt = S_FINAL;
        end else if (!stat.pend_v || stat.slot_free) begin
          cmd.op    = gfrns_pkg::OP_ACCEPT;
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (stat.next_end) begin
          state_nxt = S_ADV;
        end else begin
          cmd.op    = gfrns_pkg::OP_NEXT;
          axis_nxt  = 2'd0;
          state_nxt = S_DMUL;
        end
      end
      S_FINAL: begin
        if (!stat.pend_v) begin
          state_nxt = S_IDLE;
        end else if (stat.slot_free) begin
          cmd.op    = gfrns_pkg::OP_FINAL;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      axis_r     <= 2'd0;
      st_r       <= gfrns_pkg::ST_OK;
      is_query_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      axis_r     <= axis_nxt;
      st_r       <= st_nxt;
      is_query_r <= is_query_nxt;
    end
  end

endmodule

### rtl/gfrns_datapath.sv
// Datapath: configuration, particle and cell memories, shared multiplier, result register.
module gfrns_datapath #(
  parameter int GRID_X        = 16,
  parameter int GRID_Y        = 16,
  parameter int GRID_Z        = 16,
  parameter int MAX_NEIGHBORS = 64
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  gfrns_pkg::dp_cmd_t                     cmd,
  output gfrns_pkg::dp_stat_t                    stat,
  input  logic signed [gfrns_pkg::POS_W-1:0]     in_pos_x,
  input  logic signed [gfrns_pkg::POS_W-1:0]     in_pos_y,
  input  logic signed [gfrns_pkg::POS_W-1:0]     in_pos_z,
  input  logic [gfrns_pkg::IDX_W-1:0]            in_query_index,
  input  logic                                   cfg_valid,
  input  logic [gfrns_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gfrns_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [1:0]                             out_status,
  output logic [gfrns_pkg::IDX_W-1:0]            out_assigned_index,
  output logic [gfrns_pkg::IDX_W-1:0]            out_neighbor_index,
  output logic                                   out_last,
  output logic                                   out_truncated
);

  localparam int IDX_W  = gfrns_pkg::IDX_W;
  localparam int CNT_W  = gfrns_pkg::CNT_W;
  localparam int POS_W  = gfrns_pkg::POS_W;
  localparam int DIFF_W = gfrns_pkg::DIFF_W;
  localparam int PROD_W = gfrns_pkg::PROD_W;
  localparam int SQ_W   = gfrns_pkg::SQ_W;
  localparam int ACC_W  = gfrns_pkg::ACC_W;
  localparam int SH     = gfrns_pkg::FRAC_SHIFT;
  localparam int NPART  = gfrns_pkg::MAX_PARTICLES;
  localparam int NCELLS = GRID_X * GRID_Y * GRID_Z;
  localparam int CELL_W = $clog2(NCELLS);
  localparam int GMAX   = (GRID_X > GRID_Y) ? ((GRID_X > GRID_Z) ? GRID_X : GRID_Z)
                                            : ((GRID_Y > GRID_Z) ? GRID_Y : GRID_Z);
  localparam int CW     = $clog2(GMAX);
  localparam int NB_W   = $clog2(MAX_NEIGHBORS + 1);
  localparam int T_W    = PROD_W + 2;
  localparam int HI_W   = T_W - SH;

  typedef logic [CW-1:0] crd_t;

  function automatic int grid_of(input logic [1:0] a);
    int g;
    case (a)
      2'd0:    g = GRID_X;
      2'd1:    g = GRID_Y;
      default: g = GRID_Z;
    endcase
    return g;
  endfunction

  // Configuration
  logic [gfrns_pkg::INV_W-1:0] inv_radius_r;
  logic [gfrns_pkg::RSQ_W-1:0] radius_sq_r;
  logic signed [POS_W-1:0]     center_r [3];

  // Working registers
  logic signed [POS_W-1:0] lpos_r [3];
  logic [IDX_W-1:0]        qidx_r;
  logic [CNT_W-1:0]        count_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]        acc_r;
  logic                    outside_r;
  crd_t                    tgt_r [3];
  crd_t                    qc_r [3];
  logic signed [POS_W-1:0] qpos_r [3];
  logic [1:0]              off_r [3];
  logic                    hit_r;
  logic                    head_lt_r;
  logic [IDX_W-1:0]        cur_p_r;
  logic [IDX_W-1:0]        pend_p_r;
  logic                    pend_v_r;
  logic                    more_r;
  logic [NB_W-1:0]         n_r;

  // Memories and their registered read data
  logic [3*POS_W-1:0] pos_mem   [NPART];
  logic [3*CW-1:0]    pcell_mem [NPART];
  logic [IDX_W:0]     next_mem  [NPART];
  logic [IDX_W-1:0]   head_mem  [NCELLS];
  logic [IDX_W-1:0]   tail_mem  [NCELLS];
  logic [3*POS_W-1:0] pos_q;
  logic [3*CW-1:0]    pcell_q;
  logic [IDX_W:0]     next_q;
  logic [IDX_W-1:0]   head_q;
  logic [IDX_W-1:0]   tail_q;

  // Result register
  logic                out_valid_r;
  gfrns_pkg::status_t  out_status_r;
  logic [IDX_W-1:0]    out_ai_r;
  logic [IDX_W-1:0]    out_ni_r;
  logic                out_last_r;
  logic                out_tr_r;

  logic [IDX_W-1:0]        idx;
  logic [CELL_W-1:0]       cell_addr;
  logic [3*CW-1:0]         tgt_pack;
  logic                    p_rd;
  logic [IDX_W-1:0]        p_addr;
  logic signed [DIFF_W-1:0] mul_a;
  logic signed [DIFF_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [T_W-1:0]   t_val;
  logic signed [HI_W-1:0]  t_hi;
  logic                    t_out;
  int                      nbr [3];
  logic                    slot_free;
  logic                    emit;
  gfrns_pkg::status_t      e_st;
  logic [IDX_W-1:0]        e_ai;
  logic [IDX_W-1:0]        e_ni;
  logic                    e_last;
  logic                    e_tr;
  logic [ACC_W-1:0]        dist_sum;

  assign idx       = count_r[IDX_W-1:0];
  assign tgt_pack  = {tgt_r[2], tgt_r[1], tgt_r[0]};
  assign cell_addr = CELL_W'(int'(tgt_r[0]) +
                             GRID_X * (int'(tgt_r[1]) + GRID_Y * int'(tgt_r[2])));
  assign slot_free = !out_valid_r || !out_stall;
  assign dist_sum  = acc_r + ACC_W'(prod_r[SQ_W-1:0]);

  // Shared multiplier: cell scaling on load, squared difference on query
  always_comb begin
    if (cmd.op == gfrns_pkg::OP_LMUL) begin
      mul_a = DIFF_W'(lpos_r[cmd.axis]) - DIFF_W'(center_r[cmd.axis]);
      mul_b = $signed({1'b0, inv_radius_r});
    end else begin
      mul_a = DIFF_W'(qpos_r[cmd.axis]) -
              DIFF_W'($signed(pos_q[cmd.axis*POS_W +: POS_W]));
      mul_b = mul_a;
    end
    mul_p = mul_a * mul_b;
  end

  // Cell coordinate from the scaled offset
  always_comb begin
    t_val = T_W'(prod_r) + T_W'(grid_of(cmd.axis)) * (T_W'(1) <<< (SH - 1));
    t_hi  = t_val[T_W-1:SH];
    t_out = t_val[T_W-1] || (t_hi >= HI_W'(grid_of(cmd.axis)));
  end

  // Neighbor cell around the query cell
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nbr[k] = int'(qc_r[k]) + int'(off_r[k]) - 1;
    end
  end

  // Particle memory read address
  always_comb begin
    p_rd   = 1'b1;
    p_addr = qidx_r;
    case (cmd.op)
      gfrns_pkg::OP_QRD:     p_addr = qidx_r;
      gfrns_pkg::OP_HCHK_RD: p_addr = head_q;
      gfrns_pkg::OP_NEXT:    p_addr = next_q[IDX_W-1:0];
      default:               p_rd   = 1'b0;
    endcase
  end

  // Result selection
  always_comb begin
    emit   = 1'b0;
    e_st   = gfrns_pkg::ST_OK;
    e_ai   = '0;
    e_ni   = '0;
    e_last = 1'b1;
    e_tr   = 1'b0;
    case (cmd.op)
      gfrns_pkg::OP_CLEAR:   emit = 1'b1;
      gfrns_pkg::OP_EMIT_ST: begin
        emit = 1'b1;
        e_st = cmd.st;
      end
      gfrns_pkg::OP_STORE: begin
        emit = 1'b1;
        e_ai = idx;
      end
      gfrns_pkg::OP_ACCEPT: begin
        emit   = pend_v_r;
        e_ni   = pend_p_r;
        e_last = 1'b0;
      end
      gfrns_pkg::OP_FINAL: begin
        emit = 1'b1;
        e_ni = pend_p_r;
        e_tr = more_r;
      end
      default: emit = 1'b0;
    endcase
  end

  // Status toward the controller
  always_comb begin
    stat.full      = (count_r == CNT_W'(NPART));
    stat.q_loaded  = ({1'b0, qidx_r} < count_r);
    stat.outside   = outside_r;
    stat.hvalid    = head_lt_r && (pcell_q == tgt_pack);
    stat.nbr_in    = (nbr[0] >= 0) && (nbr[0] < GRID_X) &&
                     (nbr[1] >= 0) && (nbr[1] < GRID_Y) &&
                     (nbr[2] >= 0) && (nbr[2] < GRID_Z);
    stat.off_last  = (off_r[0] == 2'd2) && (off_r[1] == 2'd2) && (off_r[2] == 2'd2);
    stat.hit       = hit_r;
    stat.n_full    = (n_r == NB_W'(MAX_NEIGHBORS));
    stat.pend_v    = pend_v_r;
    stat.next_end  = next_q[IDX_W];
    stat.slot_free = slot_free;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_radius_r <= 24'd65536;
      radius_sq_r  <= 48'd16777216;
      center_r[0]  <= '0;
      center_r[1]  <= '0;
      center_r[2]  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        gfrns_pkg::CFG_INV_RADIUS: inv_radius_r <= cfg_data[gfrns_pkg::INV_W-1:0];
        gfrns_pkg::CFG_RADIUS_SQ:  radius_sq_r  <= cfg_data[gfrns_pkg::RSQ_W-1:0];
        gfrns_pkg::CFG_CENTER_X:   center_r[0]  <= $signed(cfg_data[POS_W-1:0]);
        gfrns_pkg::CFG_CENTER_Y:   center_r[1]  <= $signed(cfg_data[POS_W-1:0]);
        gfrns_pkg::CFG_CENTER_Z:   center_r[2]  <= $signed(cfg_data[POS_W-1:0]);
        default: ;
      endcase
    end
  end

  // Control state: fill count, pending neighbor, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == gfrns_pkg::OP_CLEAR) begin
        count_r <= '0;
      end else if (cmd.op == gfrns_pkg::OP_STORE) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.op == gfrns_pkg::OP_QLD || cmd.op == gfrns_pkg::OP_FINAL) begin
        pend_v_r <= 1'b0;
      end else if (cmd.op == gfrns_pkg::OP_ACCEPT) begin
        pend_v_r <= 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      gfrns_pkg::OP_CAPTURE: begin
        lpos_r[0] <= in_pos_x;
        lpos_r[1] <= in_pos_y;
        lpos_r[2] <= in_pos_z;
        qidx_r    <= in_query_index;
        outside_r <= 1'b0;
      end
      gfrns_pkg::OP_LMUL: prod_r <= mul_p;
      gfrns_pkg::OP_LCELL: begin
        tgt_r[cmd.axis] <= t_val[SH +: CW];
        if (t_out) begin
          outside_r <= 1'b1;
        end
      end
      gfrns_pkg::OP_HCHK_RD: begin
        head_lt_r <= ({1'b0, head_q} < count_r);
        cur_p_r   <= head_q;
      end
      gfrns_pkg::OP_QLD: begin
        for (int k = 0; k < 3; k++) begin
          qpos_r[k] <= $signed(pos_q[k*POS_W +: POS_W]);
          qc_r[k]   <= pcell_q[k*CW +: CW];
          off_r[k]  <= 2'd0;
        end
        n_r    <= '0;
        more_r <= 1'b0;
      end
      gfrns_pkg::OP_NBR: begin
        for (int k = 0; k < 3; k++) begin
          tgt_r[k] <= CW'(nbr[k]);
        end
      end
      gfrns_pkg::OP_ADV: begin
        if (off_r[2] != 2'd2) begin
          off_r[2] <= off_r[2] + 2'd1;
        end else begin
          off_r[2] <= 2'd0;
          if (off_r[1] != 2'd2) begin
            off_r[1] <= off_r[1] + 2'd1;
          end else begin
            off_r[1] <= 2'd0;
            off_r[0] <= off_r[0] + 2'd1;
          end
        end
      end
      gfrns_pkg::OP_DMUL: begin
        prod_r <= mul_p;
        acc_r  <= (cmd.axis == 2'd0) ? '0 : dist_sum;
      end
      gfrns_pkg::OP_DSUM: hit_r <= (dist_sum < ACC_W'(radius_sq_r));
      gfrns_pkg::OP_ACCEPT: begin
        pend_p_r <= cur_p_r;
        n_r      <= n_r + NB_W'(1);
      end
      gfrns_pkg::OP_MORE: more_r <= 1'b1;
      gfrns_pkg::OP_NEXT: cur_p_r <= next_q[IDX_W-1:0];
      default: ;
    endcase
  end

  // Particle memories
  always_ff @(posedge clk) begin
    if (cmd.op == gfrns_pkg::OP_STORE) begin
      pos_mem[idx]   <= {lpos_r[2], lpos_r[1], lpos_r[0]};
      pcell_mem[idx] <= tgt_pack;
    end
    if (p_rd) begin
      pos_q   <= pos_mem[p_addr];
      pcell_q <= pcell_mem[p_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == gfrns_pkg::OP_STORE) begin
      next_mem[idx] <= {1'b1, {IDX_W{1'b0}}};
    end else if (cmd.op == gfrns_pkg::OP_LINK) begin
      next_mem[tail_q] <= {1'b0, idx};
    end
    if (p_rd) begin
      next_q <= next_mem[p_addr];
    end
  end

  // Cell list memories
  always_ff @(posedge clk) begin
    if (cmd.op == gfrns_pkg::OP_SETHEAD) begin
      head_mem[cell_addr] <= idx;
    end
    if (cmd.op == gfrns_pkg::OP_HEAD_RD) begin
      head_q <= head_mem[cell_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == gfrns_pkg::OP_STORE) begin
      tail_mem[cell_addr] <= idx;
    end
    if (cmd.op == gfrns_pkg::OP_HEAD_RD) begin
      tail_q <= tail_mem[cell_addr];
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= e_st;
      out_ai_r     <= e_ai;
      out_ni_r     <= e_ni;
      out_last_r   <= e_last;
      out_tr_r     <= e_tr;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_assigned_index = out_ai_r;
  assign out_neighbor_index = out_ni_r;
  assign out_last           = out_last_r;
  assign out_truncated      = out_tr_r;

endmodule

### rtl/gfrns_checker.sv
// Port-level checker for the neighbor search top level, with its bind.
module gfrns_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [1:0]                  in_func,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [1:0]                  out_status,
  input logic [gfrns_pkg::IDX_W-1:0] out_assigned_index,
  input logic [gfrns_pkg::IDX_W-1:0] out_neighbor_index,
  input logic                        out_last,
  input logic                        out_truncated
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_neighbor_index) && $stable(out_last))
    else $error("stalled result changed");

  // A working request blocks the next one
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_func != gfrns_pkg::FUNC_NOP) |=> in_stall)
    else $error("request taken while busy");

  // Error status always closes the request
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != gfrns_pkg::ST_OK) |-> out_last && (out_neighbor_index == '0))
    else $error("error result not final");

  // Only the final neighbor may carry truncation; mid results are neighbors
  a_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !out_truncated && (out_assigned_index == '0) &&
    (out_status == gfrns_pkg::ST_OK))
    else $error("bad intermediate result");

endmodule

bind grid_fixed_radius_neighbor_search gfrns_checker u_gfrns_checker (.*);
